### rtl/iida_pkg.sv
// ----------------------------------------------------------------------------
// iida_pkg: shared types and codes for the insert/delete array unit
// Action and status codes, the command that drives the chain of cells.
// ----------------------------------------------------------------------------
package iida_pkg;

  // Default and largest supported list depth
  localparam int DEF_CAPACITY = 16;
  localparam int MAX_CAPACITY = 64;

  // Width of slot numbers and counts carried to the cells
  localparam int CNT_W = $clog2(MAX_CAPACITY + 1);

  localparam int ACTION_W = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int EIDX_W   = 4;

  // Longest read-out, in items
  localparam int MAX_OUT = 16;

  localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DROP     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ_ALL = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd3;

  // What every cell does to its word
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,  // open slot at pos, later cells take the left word
    OP_APPEND = 3'd2,  // slot cnt takes the new word
    OP_DELETE = 3'd3,  // cells from pos to cnt-2 take the right word
    OP_ROTATE = 3'd4   // move one place toward slot 0, head wraps to cnt-1
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] pos;  // zero-based slot
    logic [CNT_W-1:0] cnt;  // entries stored before the edit
  } chain_cmd_t;

endpackage

### rtl/indexed_insert_delete_array_unit.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_unit: bounded ordered list of signed words
// Insert/append/delete/drop/read-all over a chain of CAPACITY cells.
// ----------------------------------------------------------------------------
// Usage:
//   An item (action, position, value) is taken at a rising edge with start
//   high and busy low. Results come out on registered ports for one cycle,
//   marked by valid and registered at the edge that produced them; the
//   receiver cannot stall them.
//   Edits (insert, append, delete, drop, unused codes) and rejected requests
//   give one status result, registered at acceptance; busy stays low, so a
//   new item may follow in every cycle.
//   Read-all on a non-empty list rotates the chain one place per cycle and
//   reports cell 0 each cycle: min(count,16) results, the last one marked by
//   last. The rotation runs through all count entries so the list ends in its
//   original order; busy is high until it ends. Read-all of an empty list
//   gives one status result like an edit.
//   The chain sets the pace: every cell shifts at once, one step per cycle.
//   Reset (rst, synchronous) empties the list and drops any read-out in
//   progress; stored words are not cleared, since only slots below count are
//   ever read.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_unit #(
  parameter int CAPACITY = iida_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [iida_pkg::ACTION_W-1:0] action,
  input  logic [iida_pkg::POS_W-1:0]    position,
  input  logic signed [iida_pkg::DATA_W-1:0] value,
  output logic                          valid,
  output logic [iida_pkg::STATUS_W-1:0] status,
  output logic [iida_pkg::COUNT_W-1:0]  count,
  output logic                          has_element,
  output logic [iida_pkg::EIDX_W-1:0]   element_index,
  output logic signed [iida_pkg::DATA_W-1:0] element_value,
  output logic                          last
);
  import iida_pkg::*;

  // Count register width, compare width covering count, position and 16
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int BASEW = (CW > POS_W) ? CW : POS_W;
  localparam int W     = BASEW + 1;

  localparam logic [W-1:0] CAP_W   = W'(CAPACITY);
  localparam logic [W-1:0] MAXO_W  = W'(MAX_OUT);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   entry_count, entry_count_next;
  logic [CW-1:0]   rd_idx, rd_idx_next;

  // Chain wiring
  chain_cmd_t        cmd;
  logic [DATA_W-1:0] cell_word [CAPACITY];

  // Result values for the coming cycle
  logic              res_valid;
  logic [STATUS_W-1:0] res_status;
  logic              res_has;
  logic              res_last;

  logic              take;
  logic [W-1:0]      cnt_w, pos_w, rd_w, n_w;
  logic [W-1:0]      cnt_ext, idx_ext;

  assign take  = start && (state == S_IDLE);
  assign busy  = (state == S_READ);
  assign cnt_w = W'(entry_count);
  assign pos_w = W'(position);
  assign rd_w  = W'(rd_idx);
  // Entries reported by one read-out
  assign n_w   = (cnt_w < MAXO_W) ? cnt_w : MAXO_W;

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    rd_idx_next      = rd_idx;
    cmd.op           = OP_HOLD;
    cmd.pos          = CNT_W'(position) - CNT_W'(1);
    cmd.cnt          = CNT_W'(entry_count);
    res_valid        = 1'b0;
    res_status       = ST_OK;
    res_has          = 1'b0;
    res_last         = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (take) begin
          res_valid = 1'b1;
          case (action)
            ACT_INSERT: begin
              if (cnt_w >= CAP_W) begin
                res_status = ST_FULL;
              end else if (pos_w == '0 || pos_w > cnt_w + W'(1)) begin
                res_status = ST_BAD_POS;
              end else begin
                cmd.op           = OP_INSERT;
                entry_count_next = entry_count + CW'(1);
              end
            end
            ACT_APPEND: begin
              if (cnt_w >= CAP_W) begin
                res_status = ST_FULL;
              end else begin
                cmd.op           = OP_APPEND;
                entry_count_next = entry_count + CW'(1);
              end
            end
            ACT_DELETE: begin
              if (cnt_w == '0) begin
                res_status = ST_EMPTY;
              end else if (pos_w == '0 || pos_w > cnt_w) begin
                res_status = ST_BAD_POS;
              end else begin
                cmd.op           = OP_DELETE;
                entry_count_next = entry_count - CW'(1);
              end
            end
            ACT_DROP: begin
              if (cnt_w == '0) begin
                res_status = ST_EMPTY;
              end else begin
                entry_count_next = entry_count - CW'(1);
              end
            end
            ACT_READ_ALL: begin
              // Non-empty: results come from the rotation cycles instead
              if (cnt_w != '0) begin
                res_valid   = 1'b0;
                rd_idx_next = '0;
                state_next  = S_READ;
              end
            end
            default: begin
              // unused action codes: plain ok status
            end
          endcase
        end
      end
      S_READ: begin
        cmd.op      = OP_ROTATE;
        res_valid   = (rd_w < n_w);
        res_has     = 1'b1;
        res_last    = (rd_w == n_w - W'(1));
        rd_idx_next = rd_idx + CW'(1);
        if (rd_w == cnt_w - W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Chain of cells; ends of the chain see zero neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    iida_cell #(
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_word  (value),
      .left_word (left_w),
      .right_word(right_w),
      .head_word (cell_word[0]),
      .word      (cell_word[i])
    );
  end

  // Zero-extended views for the narrow result fields
  assign cnt_ext = W'(entry_count_next);
  assign idx_ext = W'(rd_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rd_idx      <= '0;
      valid       <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      rd_idx      <= rd_idx_next;
      valid       <= res_valid;
    end
  end

  // Result payload; meaningful only while valid is high
  always_ff @(posedge clk) begin
    status        <= res_status;
    count         <= cnt_ext[COUNT_W-1:0];
    has_element   <= res_has;
    element_index <= res_has ? idx_ext[EIDX_W-1:0] : '0;
    element_value <= res_has ? cell_word[0] : '0;
    last          <= res_last;
  end

endmodule

### rtl/iida_cell.sv
// ----------------------------------------------------------------------------
// iida_cell: one slot of the list
// Holds one word; each cycle keeps it or takes a neighbor, head or new word.
// ----------------------------------------------------------------------------
module iida_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  iida_pkg::chain_cmd_t      cmd,
  input  logic [iida_pkg::DATA_W-1:0] new_word,
  input  logic [iida_pkg::DATA_W-1:0] left_word,
  input  logic [iida_pkg::DATA_W-1:0] right_word,
  input  logic [iida_pkg::DATA_W-1:0] head_word,
  output logic [iida_pkg::DATA_W-1:0] word
);
  import iida_pkg::*;

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic [CNT_W-1:0]  cnt_m1;
  logic [DATA_W-1:0] word_next;

  assign cnt_m1 = cmd.cnt - CNT_W'(1);

  always_comb begin
    word_next = word;
    unique case (cmd.op)
      OP_INSERT: begin
        if (IDX == cmd.pos) begin
          word_next = new_word;
        end else if (IDX > cmd.pos && IDX <= cmd.cnt) begin
          word_next = left_word;
        end
      end
      OP_APPEND: begin
        if (IDX == cmd.cnt) begin
          word_next = new_word;
        end
      end
      OP_DELETE: begin
        if (IDX >= cmd.pos && IDX < cnt_m1) begin
          word_next = right_word;
        end
      end
      OP_ROTATE: begin
        if (IDX < cnt_m1) begin
          word_next = right_word;
        end else if (IDX == cnt_m1) begin
          word_next = head_word;
        end
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

### tb/sv/tb_indexed_insert_delete_array_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_insert_delete_array_unit: self-checking bench for the list unit
// Drives insert/append/delete/drop/read-all items through the start/busy
// handshake and keeps a shadow list. Every strobed result is checked field by
// field against the results that the shadow list predicts.
// ----------------------------------------------------------------------------
module tb_indexed_insert_delete_array_unit;
  import iida_pkg::*;

  localparam int LIST_CAP       = DEF_CAPACITY;
  localparam int RANDOM_ITEMS   = 85;
  localparam int QUIET_LIMIT    = 300;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES   = 20;   // > longest read-out
  localparam int NO_IDLE_TAIL   = 15;   // last items go back to back

  typedef struct packed {
    logic [ACTION_W-1:0]      act;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] word;
  } list_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic                     has_element;
    logic [EIDX_W-1:0]        element_index;
    logic signed [DATA_W-1:0] element_value;
    logic                     last;
  } list_result_t;

  // DUT ports; every input starts at a known value
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [ACTION_W-1:0]      action = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     valid;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;
  logic                     has_element;
  logic [EIDX_W-1:0]        element_index;
  logic signed [DATA_W-1:0] element_value;
  logic                     last;

  // Items waiting to be sent, and results the shadow list says must come
  list_request_t pending_requests[$];
  list_result_t  awaited_results[$];

  // Shadow copy of the list
  logic signed [DATA_W-1:0] list_words[LIST_CAP];
  int list_len = 0;

  // Length the generator believes the list has, used to aim positions
  int gen_len = 0;

  int failures        = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int read_outs       = 0;
  int full_peak_hits  = 0;
  int status_hits[4]  = '{0, 0, 0, 0};
  int idle_left       = 0;

  indexed_insert_delete_array_unit #(.CAPACITY(LIST_CAP)) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .position     (position),
    .value        (value),
    .valid        (valid),
    .status       (status),
    .count        (count),
    .has_element  (has_element),
    .element_index(element_index),
    .element_value(element_value),
    .last         (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow list: the results one accepted item must produce
  // --------------------------------------------------------------------------
  function automatic void push_result(logic [STATUS_W-1:0] st, logic has, int idx,
                                      logic signed [DATA_W-1:0] word, logic is_last);
    list_result_t r;
    r.status        = st;
    r.count         = COUNT_W'(list_len);
    r.has_element   = has;
    r.element_index = has ? EIDX_W'(idx) : '0;
    r.element_value = has ? word : '0;
    r.last          = is_last;
    awaited_results.push_back(r);
    status_hits[st]++;
  endfunction

  function automatic void apply_list_action(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                            logic signed [DATA_W-1:0] word);
    int p;
    int slot;
    int n;
    logic [STATUS_W-1:0] st;
    p  = int'(pos);
    st = ST_OK;
    case (act)
      ACT_INSERT: begin
        // full is tested ahead of the position
        if (list_len >= LIST_CAP) begin
          st = ST_FULL;
        end else if (p < 1 || p > list_len + 1) begin
          st = ST_BAD_POS;
        end else begin
          for (slot = list_len; slot > p - 1; slot--) list_words[slot] = list_words[slot-1];
          list_words[p-1] = word;
          list_len++;
        end
      end
      ACT_APPEND: begin
        if (list_len >= LIST_CAP) begin
          st = ST_FULL;
        end else begin
          list_words[list_len] = word;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          st = ST_BAD_POS;
        end else begin
          for (slot = p - 1; slot + 1 < list_len; slot++) list_words[slot] = list_words[slot+1];
          list_len--;
        end
      end
      ACT_DROP: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_len--;
      end
      ACT_READ_ALL: begin
        // non-empty read-out: one result per entry, capped at MAX_OUT
        if (list_len > 0) begin
          n = (list_len < MAX_OUT) ? list_len : MAX_OUT;
          for (slot = 0; slot < n; slot++)
            push_result(ST_OK, 1'b1, slot, list_words[slot], slot == n - 1);
          read_outs++;
          return;
        end
      end
      default: ;  // unused codes: plain ok status
    endcase
    if (list_len == LIST_CAP && (act == ACT_INSERT || act == ACT_APPEND) && st == ST_OK)
      full_peak_hits++;
    push_result(st, 1'b0, 0, '0, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                      logic signed [DATA_W-1:0] word);
    int p;
    list_request_t rq;
    p       = int'(pos);
    rq.act  = act;
    rq.pos  = pos;
    rq.word = word;
    pending_requests.push_back(rq);
    // keep the generator's idea of the length in step
    case (act)
      ACT_INSERT: if (gen_len < LIST_CAP && p >= 1 && p <= gen_len + 1) gen_len++;
      ACT_APPEND: if (gen_len < LIST_CAP) gen_len++;
      ACT_DELETE: if (gen_len > 0 && p >= 1 && p <= gen_len) gen_len--;
      ACT_DROP:   if (gen_len > 0) gen_len--;
      default: ;
    endcase
  endfunction

  // mostly random words, with the corner values mixed in
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers the next item, holds it while busy, records it on accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    list_request_t rq;
    bit            may_offer;
    bit            idle_ok;
    if (rst) begin
      start     <= 1'b0;
      idle_left = 0;
    end else begin
      may_offer = 1'b1;
      if (start) begin
        if (!busy) begin
          apply_list_action(action, position, value);
          items_accepted++;
        end else begin
          may_offer = 1'b0;  // item stays on the ports until taken
        end
      end
      if (may_offer) begin
        // idle bursts only outside quiet stretches and before the tail
        idle_ok = pending_requests.size() > NO_IDLE_TAIL &&
                  (pending_requests.size() % 40) < 28;
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          start <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 3) == 0) begin
          idle_left = $urandom_range(1, 7) - 1;
          start <= 1'b0;
        end else begin
          rq = pending_requests.pop_front();
          start    <= 1'b1;
          action   <= rq.act;
          position <= rq.pos;
          value    <= rq.word;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobed result against the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    list_result_t want;
    if (!rst && valid) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none expected, status %0d count %0d value %0h",
                 $time, status, count, element_value);
        failures++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status",        want.status,        status);
        check_field("count",         want.count,         count);
        check_field("has_element",   want.has_element,   has_element);
        check_field("element_index", want.element_index, element_index);
        check_field("element_value", want.element_value, element_value);
        check_field("last",          want.last,          last);
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a long stretch with neither an accept nor a result is a hang
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || valid) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : sequencer
    int                  k;
    int                  r;
    logic [ACTION_W-1:0] a;
    logic [POS_W-1:0]    p;
    bit                  filling;

    // Directed: empty-list rejects and read, bad insert positions
    add_request(ACT_READ_ALL, 5'd0, '0);
    add_request(ACT_DROP,     5'd0, '0);
    add_request(ACT_DELETE,   5'd1, '0);
    add_request(ACT_INSERT,   5'd0, 32'sd5);
    add_request(ACT_INSERT,   5'd2, 32'sd6);
    // head, tail and middle inserts with extreme words
    add_request(ACT_INSERT,   5'd1, 32'sh8000_0000);
    add_request(ACT_APPEND,   5'd0, 32'sh7FFF_FFFF);
    add_request(ACT_INSERT,   5'd2, -32'sd1);
    // fill to capacity, inserts spread over the list
    k = 0;
    while (gen_len < LIST_CAP) begin
      if (k[0]) add_request(ACT_APPEND, 5'd0, pick_word());
      else add_request(ACT_INSERT, POS_W'($urandom_range(1, gen_len + 1)), pick_word());
      k++;
    end
    // full list: full status wins over a bad position
    add_request(ACT_APPEND,   5'd0,  32'sd1);
    add_request(ACT_INSERT,   5'd31, 32'sd2);
    add_request(ACT_READ_ALL, 5'd0,  '0);
    add_request(ACT_DELETE,   5'd17, '0);
    add_request(ACT_DELETE,   5'd1,  '0);
    add_request(ACT_DELETE,   5'd15, '0);
    add_request(ACT_DROP,     5'd0,  '0);

    // Random: fill/drain sweeps with aimed positions, some noise
    filling = 1'b0;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (gen_len == 0) filling = 1'b1;
      else if (gen_len == LIST_CAP) filling = 1'b0;
      else if ($urandom_range(0, 19) == 0) filling = ~filling;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        a = ACTION_W'($urandom_range(5, 7));           // unused codes
      end else if (r < 15) begin
        a = ACT_READ_ALL;
      end else if (filling ? (r < 83) : (r >= 83)) begin
        a = $urandom_range(0, 1) ? ACT_INSERT : ACT_APPEND;
      end else begin
        a = $urandom_range(0, 1) ? ACT_DELETE : ACT_DROP;
      end
      // mostly legal positions; the rest anywhere in the field
      if ($urandom_range(0, 99) < 15) p = POS_W'($urandom);
      else if (a == ACT_INSERT) p = POS_W'($urandom_range(1, gen_len + 1));
      else if (a == ACT_DELETE && gen_len > 0) p = POS_W'($urandom_range(1, gen_len));
      else p = POS_W'($urandom);
      add_request(a, p, pick_word());
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // all items taken, all results in, then let the pipe settle
    while (pending_requests.size() > 0 || start) @(negedge clk);
    while (awaited_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d items and %0d results, %0d read-outs, %0d fills to capacity",
             items_accepted, results_checked, read_outs, full_peak_hits);
    $display("Status counts ok/full/empty/bad position: %0d/%0d/%0d/%0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_BAD_POS]);
    if (failures == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### indexed_insert_delete_array_unit.f
rtl/iida_pkg.sv
rtl/iida_cell.sv
rtl/indexed_insert_delete_array_unit.sv
tb/sv/tb_indexed_insert_delete_array_unit.sv
